### sv/hstp_pkg.sv
// shared types, constants and helpers for the triangular-probe hash set
// used by the controller, datapath, top level and checker; no dependencies

package hstp_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int KEY_BITS    = 32;
    localparam int LG_BITS     = 4;
    localparam int LG_MIN      = 2;
    localparam int LG_RESET    = 10;
    localparam int BUDGET_MAX  = (TABLE_SLOTS * 2) / 3;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [LG_BITS-1:0]   t_lg;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_PLACE  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    // what the output register is loaded with
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FOUND,
        RES_PLACED,
        RES_FULL,
        RES_READ
    } t_res;

    typedef struct packed {
        logic load_in;
        logic advance;
        logic sweep;
        logic budget_reload;
        logic place_wr;
        logic ld_out;
        t_res res;
    } t_cmd;

    typedef struct packed {
        t_mode in_mode;
        logic  in_hash_zero;
        t_mode mode;
        logic  hit;
        logic  empty;
        logic  last;
        logic  sweep_last;
        logic  out_free;
    } t_stat;

    // log2 of capacity in use, clamped to the physical table
    function automatic t_lg eff_log2(input t_lg lg);
        t_lg r;
        r = lg;
        if (lg < t_lg'(LG_MIN)) r = t_lg'(LG_MIN);
        if (lg > t_lg'(SLOT_BITS)) r = t_lg'(SLOT_BITS);
        return r;
    endfunction

    function automatic t_slot cap_mask(input t_lg lg);
        logic [SLOT_BITS:0] cap;
        cap = (SLOT_BITS+1)'(1) << eff_log2(lg);
        return t_slot'(cap - (SLOT_BITS+1)'(1));
    endfunction

    // two thirds of the capacity in use, rounded down
    function automatic t_slot budget_for(input t_lg lg);
        t_slot b;
        unique case (eff_log2(lg))
            4'd2:    b = t_slot'(2);
            4'd3:    b = t_slot'(5);
            4'd4:    b = t_slot'(10);
            4'd5:    b = t_slot'(21);
            4'd6:    b = t_slot'(42);
            4'd7:    b = t_slot'(85);
            4'd8:    b = t_slot'(170);
            4'd9:    b = t_slot'(341);
            default: b = t_slot'(BUDGET_MAX);
        endcase
        return b;
    endfunction

endpackage

### sv/hstp_ram.sv
// generic single write port, single read port ram with registered read data
// no package dependencies

module hstp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/hstp_ctrl.sv
// sequencer for the hash set: reset/clear sweep, probe loop, slot read, result hand-off
// depends on hstp_pkg

module hstp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hstp_pkg::t_stat i_stat,
    output hstp_pkg::t_cmd  o_cmd
);
    import hstp_pkg::*;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_PROBE,
        S_READ,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_item, n_clr_item;
    t_cmd   cmd;
    logic   decided;

    always_comb begin
        n_state    = r_state;
        n_clr_item = r_clr_item;
        cmd        = '0;
        cmd.res    = RES_ZERO;
        decided    = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    if (r_clr_item) begin
                        cmd.budget_reload = 1'b1;
                        n_clr_item        = 1'b0;
                        n_state           = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    unique case (i_stat.in_mode)
                        MODE_LOOKUP: n_state = i_stat.in_hash_zero ? S_FIN : S_PROBE;
                        MODE_PLACE:  n_state = S_PROBE;
                        MODE_CLEAR: begin
                            n_state    = S_SWEEP;
                            n_clr_item = 1'b1;
                        end
                        MODE_READ:   n_state = S_READ;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_PROBE: begin
                if (i_stat.mode == MODE_PLACE) begin
                    priority if (i_stat.empty) begin
                        cmd.res = RES_PLACED;
                        decided = 1'b1;
                    end else if (i_stat.last) begin
                        cmd.res = RES_FULL;
                        decided = 1'b1;
                    end else begin
                        decided = 1'b0;
                    end
                end else begin
                    priority if (i_stat.hit) begin
                        cmd.res = RES_FOUND;
                        decided = 1'b1;
                    end else if (i_stat.empty) begin
                        decided = 1'b1;
                    end else if (i_stat.last) begin
                        cmd.res = RES_FULL;
                        decided = 1'b1;
                    end else begin
                        decided = 1'b0;
                    end
                end
                if (!decided) begin
                    cmd.advance = 1'b1;
                end else if (i_stat.out_free) begin
                    cmd.ld_out   = 1'b1;
                    cmd.place_wr = (cmd.res == RES_PLACED);
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                cmd.res = RES_READ;
                if (i_stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

    assign o_cmd = cmd;

endmodule

### sv/hstp_dpath.sv
// datapath: capacity register, probe index and step, budget, key and occupancy rams,
// output register; depends on hstp_pkg and hstp_ram

module hstp_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  hstp_pkg::t_lg         i_cfg_data,
    input  logic [1:0]            i_mode,
    input  hstp_pkg::t_key        i_key,
    input  logic [31:0]           i_key_hash,
    input  hstp_pkg::t_slot       i_slot_index,
    input  hstp_pkg::t_cmd        i_cmd,
    output hstp_pkg::t_stat       o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output hstp_pkg::t_slot       o_where_slot,
    output logic                  o_entry_valid,
    output hstp_pkg::t_key        o_entry_key,
    output hstp_pkg::t_slot       o_remaining_slots,
    output logic                  o_status
);
    import hstp_pkg::*;

    t_lg   r_cap_lg;
    t_mode r_mode;
    t_key  r_key;
    t_slot r_idx, n_idx;
    t_slot r_n, n_n;
    t_slot r_sweep;
    t_slot r_budget, n_budget;
    t_slot mask;
    logic [SLOT_BITS:0] step_sum;

    logic  r_out_valid;
    logic  r_found, r_entry_valid, r_status;
    t_slot r_where;
    t_key  r_entry_key;
    t_slot r_remaining;

    logic  rd_valid;
    t_key  rd_key;
    logic  v_we, v_wdata;
    t_slot v_waddr;

    assign mask     = cap_mask(r_cap_lg);
    // triangular step: next = idx + n + 1
    assign step_sum = {1'b0, r_idx} + {1'b0, r_n} + (SLOT_BITS+1)'(1);

    always_comb begin
        n_idx = r_idx;
        n_n   = r_n;
        if (i_cmd.load_in) begin
            n_n = '0;
            if (t_mode'(i_mode) == MODE_READ) begin
                n_idx = i_slot_index & mask;
            end else begin
                n_idx = i_key_hash[SLOT_BITS-1:0] & mask;
            end
        end else if (i_cmd.advance) begin
            n_idx = step_sum[SLOT_BITS-1:0] & mask;
            n_n   = r_n + t_slot'(1);
        end
    end

    always_comb begin
        n_budget = r_budget;
        if (i_cmd.budget_reload) begin
            n_budget = budget_for(r_cap_lg);
        end else if (i_cmd.place_wr && (r_budget != '0)) begin
            n_budget = r_budget - t_slot'(1);
        end
    end

    // sweep clears occupancy; a placement sets it
    assign v_we    = i_cmd.sweep | i_cmd.place_wr;
    assign v_waddr = i_cmd.sweep ? r_sweep : r_idx;
    assign v_wdata = ~i_cmd.sweep;

    hstp_ram #(
        .WIDTH(1),
        .DEPTH(TABLE_SLOTS)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (n_idx),
        .o_rdata (rd_valid)
    );

    hstp_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(TABLE_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.place_wr),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_raddr (n_idx),
        .o_rdata (rd_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_lg    <= t_lg'(LG_RESET);
            r_budget    <= t_slot'(BUDGET_MAX);
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap_lg <= i_cfg_data;
            end
            r_budget <= n_budget;
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + t_slot'(1);
            end
            if (i_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_n   <= n_n;
        if (i_cmd.load_in) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_key;
        end
        if (i_cmd.ld_out) begin
            r_found       <= 1'b0;
            r_where       <= '0;
            r_entry_valid <= 1'b0;
            r_entry_key   <= '0;
            r_status      <= 1'b0;
            unique case (i_cmd.res)
                RES_ZERO: ;
                RES_FOUND: begin
                    r_found <= 1'b1;
                    r_where <= r_idx;
                end
                RES_PLACED: r_where <= r_idx;
                RES_FULL:   r_status <= 1'b1;
                RES_READ: begin
                    r_where       <= r_idx;
                    r_entry_valid <= rd_valid;
                    r_entry_key   <= rd_valid ? rd_key : '0;
                end
                default: ;
            endcase
            r_remaining <= n_budget;
        end
    end

    assign o_stat.in_mode      = t_mode'(i_mode);
    assign o_stat.in_hash_zero = (i_key_hash == '0);
    assign o_stat.mode         = r_mode;
    assign o_stat.hit          = rd_valid && (rd_key == r_key);
    assign o_stat.empty        = !rd_valid;
    assign o_stat.last         = (r_n == mask);
    assign o_stat.sweep_last   = (r_sweep == t_slot'(TABLE_SLOTS - 1));
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_where_slot      = r_where;
    assign o_entry_valid     = r_entry_valid;
    assign o_entry_key       = r_entry_key;
    assign o_remaining_slots = r_remaining;
    assign o_status          = r_status;

endmodule

### sv/hash_set_triangular_probe_core.sv
// lookup or place: one slot read a cycle while probing, then the result loads; read slot and
// a lookup with a zero hash skip the probe; clear sweeps occupancy first; output stalls delay the result
// throughput: one item at a time; the next beat is taken the cycle after the result loads
// reset: synchronous, active low; then a sweep of every slot of the occupancy ram
// runs with input stalled; configuration writes are taken at any time
// top level of the hash set; depends on hstp_pkg, hstp_ctrl, hstp_dpath

module hash_set_triangular_probe_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  hstp_pkg::t_lg         i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  hstp_pkg::t_key        i_key,
    input  logic [31:0]           i_key_hash,
    input  hstp_pkg::t_slot       i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output hstp_pkg::t_slot       o_where_slot,
    output logic                  o_entry_valid,
    output hstp_pkg::t_key        o_entry_key,
    output hstp_pkg::t_slot       o_remaining_slots,
    output logic                  o_status
);
    import hstp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    hstp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hstp_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_key             (i_key),
        .i_key_hash        (i_key_hash),
        .i_slot_index      (i_slot_index),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_found           (o_found),
        .o_where_slot      (o_where_slot),
        .o_entry_valid     (o_entry_valid),
        .o_entry_key       (o_entry_key),
        .o_remaining_slots (o_remaining_slots),
        .o_status          (o_status)
    );

endmodule

### sv/hstp_checker.sv
// port-level checks for the hash set core, bound to the top level
// depends on hstp_pkg

module hstp_assert (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_found,
    input hstp_pkg::t_slot       o_where_slot,
    input logic                  o_entry_valid,
    input hstp_pkg::t_key        o_entry_key,
    input hstp_pkg::t_slot       o_remaining_slots,
    input logic                  o_status
);
    import hstp_pkg::*;

    // one item at a time: a taken beat stalls the input next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_where_slot)
            && $stable(o_remaining_slots) && $stable(o_entry_key)))
        else $error("stalled result changed");

    // a hit is never a full-table give-up nor a slot read
    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (!o_status && !o_entry_valid))
        else $error("found with status or entry_valid set");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_where_slot == '0 && !o_found))
        else $error("give-up result carries a slot");

    a_budget_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_remaining_slots <= t_slot'(BUDGET_MAX)))
        else $error("budget above two thirds of table");

endmodule

bind hash_set_triangular_probe_core hstp_assert u_hstp_assert (.*);
